// ----- hdl/ground_contact_response_macros.svh -----
// assertion macros for the ground contact response checker
`ifndef GROUND_CONTACT_RESPONSE_MACROS_SVH
`define GROUND_CONTACT_RESPONSE_MACROS_SVH
// implication checked on every clock edge outside reset
`define GCR_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// next-cycle implication
`define GCR_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

// ----- hdl/gcr_pkg.sv -----
// shared types and constants for the ground contact response block
`timescale 1ns / 1ps
package gcr_pkg;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_RESTITUTION = 3'd0;
    localparam logic [2:0] REG_PUSH_FORCE  = 3'd1;
    localparam logic [2:0] REG_REST_THRESH = 3'd2;
    localparam logic [2:0] REG_HALF_X      = 3'd3;
    localparam logic [2:0] REG_HALF_Y      = 3'd4;
    localparam logic [2:0] REG_HALF_Z      = 3'd5;

    // one corner coordinate, signed so that element selects compare as signed
    typedef logic signed [47:0] coord_t;

    // all eight corner coordinates per axis, plus carried fields
    typedef struct packed {
        logic                on_ground;
        coord_t [7:0]        cor_x;
        coord_t [7:0]        cor_y;
        coord_t [7:0]        cor_z;
        logic signed [31:0]  vel_x;
        logic signed [31:0]  vel_y;
        logic signed [31:0]  vel_z;
    } corner_item_t;

    typedef struct packed {
        logic               on_ground;
        logic signed [47:0] r_x;
        logic signed [47:0] r_z;
        logic signed [47:0] piv_x;
        logic signed [47:0] piv_y;
        logic signed [47:0] piv_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } lever_item_t;

    typedef struct packed {
        logic [15:0] restitution;
        logic [30:0] push_force;
        logic [30:0] rest_threshold;
        logic [30:0] half_x;
        logic [30:0] half_y;
        logic [30:0] half_z;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction
endpackage

// ----- hdl/ground_contact_response.sv -----
// top level of the ground contact response block
`timescale 1ns / 1ps
// One box contact per transaction; a new one may enter every cycle unless output
// back-pressure stalls the pipeline. A result passes through three front stages (axis
// products, corner sums, extreme-corner selection), a four-entry queue, then two back
// stages (torque and velocity products, saturated output register). Registers are to be
// written over the APB port only while idle; the block itself does not enforce this.
module ground_contact_response #(
    parameter int QUEUE_DEPTH = gcr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [47:0]        axis_one,
    input  logic [47:0]        axis_two,
    input  logic [47:0]        axis_three,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic               on_ground,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pivot_x,
    output logic signed [31:0] pivot_y,
    output logic signed [31:0] pivot_z,
    output logic signed [31:0] torque_x,
    output logic signed [31:0] torque_y,
    output logic signed [31:0] torque_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic               force_applied
);
    import gcr_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] ridx;
    assign ridx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.restitution    <= 16'd16384;
            cfg_reg.push_force     <= 31'd65536;
            cfg_reg.rest_threshold <= 31'd10923;
            cfg_reg.half_x         <= 31'd65536;
            cfg_reg.half_y         <= 31'd65536;
            cfg_reg.half_z         <= 31'd65536;
        end
        else if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            case (ridx)
                REG_RESTITUTION: cfg_reg.restitution <= pwdata[15:0];
                REG_PUSH_FORCE:  cfg_reg.push_force <= pwdata[30:0];
                REG_REST_THRESH: cfg_reg.rest_threshold <= pwdata[30:0];
                REG_HALF_X:      cfg_reg.half_x <= pwdata[30:0];
                REG_HALF_Y:      cfg_reg.half_y <= pwdata[30:0];
                REG_HALF_Z:      cfg_reg.half_z <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_RESTITUTION: prdata = {16'd0, cfg_reg.restitution};
            REG_PUSH_FORCE:  prdata = {1'b0, cfg_reg.push_force};
            REG_REST_THRESH: prdata = {1'b0, cfg_reg.rest_threshold};
            REG_HALF_X:      prdata = {1'b0, cfg_reg.half_x};
            REG_HALF_Y:      prdata = {1'b0, cfg_reg.half_y};
            REG_HALF_Z:      prdata = {1'b0, cfg_reg.half_z};
            default:         prdata = '0;
        endcase
    end

    logic        f_valid, f_ready, q_valid, q_ready;
    lever_item_t f_item, q_item;

    gcr_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_valid), .in_ready(in_ready),
        .cx(center_x), .cy(center_y), .cz(center_z),
        .ax1(axis_one), .ax2(axis_two), .ax3(axis_three),
        .vx(vel_x), .vy(vel_y), .vz(vel_z), .gnd(on_ground),
        .o_valid(f_valid), .o_ready(f_ready), .o_item(f_item)
    );

    gcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
        .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item)
    );

    gcr_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .i_valid(q_valid), .i_ready(q_ready), .i_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .piv_x(pivot_x), .piv_y(pivot_y), .piv_z(pivot_z),
        .tq_x(torque_x), .tq_z(torque_z),
        .nv_x(new_vel_x), .nv_y(new_vel_y), .nv_z(new_vel_z),
        .applied(force_applied)
    );

    // torque about y is always zero for a vertical push
    assign torque_y = '0;
endmodule

// ----- hdl/gcr_front.sv -----
// front end: corner products, corner sums, extreme-corner selection
`timescale 1ns / 1ps
module gcr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcr_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   cx,
    input  logic signed [31:0]   cy,
    input  logic signed [31:0]   cz,
    input  logic [47:0]          ax1,
    input  logic [47:0]          ax2,
    input  logic [47:0]          ax3,
    input  logic signed [31:0]   vx,
    input  logic signed [31:0]   vy,
    input  logic signed [31:0]   vz,
    input  logic                 gnd,
    output logic                 o_valid,
    input  logic                 o_ready,
    output gcr_pkg::lever_item_t o_item
);
    import gcr_pkg::*;

    // stage 1: nine products half*axis
    logic               s1_valid_reg;
    logic signed [47:0] prod_reg [3][3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] v_reg [3];
    logic               g_reg;
    // stage 2: corners
    logic               s2_valid_reg;
    corner_item_t       s2_reg;
    // stage 3: lever
    logic               s3_valid_reg;
    lever_item_t        s3_reg;

    logic adv3, adv2, adv1;
    assign adv3 = !s3_valid_reg || o_ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign o_valid = s3_valid_reg;
    assign o_item = s3_reg;

    logic [47:0] axes [3];
    logic [30:0] halves [3];
    assign axes[0] = ax1;
    assign axes[1] = ax2;
    assign axes[2] = ax3;
    assign halves[0] = cfg.half_x;
    assign halves[1] = cfg.half_y;
    assign halves[2] = cfg.half_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[a][c] <= 48'($signed({1'b0, halves[a]}) *
                                      $signed(axes[a][47-16*c -: 16]));
                end
            end
            c_reg[0] <= cx;
            c_reg[1] <= cy;
            c_reg[2] <= cz;
            v_reg[0] <= vx;
            v_reg[1] <= vy;
            v_reg[2] <= vz;
            g_reg <= gnd;
        end
    end

    // corner sums, floor shift by 14
    corner_item_t s2_next;
    always_comb
    begin
        logic signed [49:0] acc;
        s2_next.on_ground = g_reg;
        s2_next.vel_x = v_reg[0];
        s2_next.vel_y = v_reg[1];
        s2_next.vel_z = v_reg[2];
        for (int i = 0; i < 8; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 50'(c_reg[c]) <<< 14;
                for (int a = 0; a < 3; a++)
                begin
                    if (((i >> (2 - a)) & 1) != 0) acc = acc - 50'(prod_reg[a][c]);
                    else acc = acc + 50'(prod_reg[a][c]);
                end
                if (c == 0) s2_next.cor_x[i] = 48'(acc >>> 14);
                else if (c == 1) s2_next.cor_y[i] = 48'(acc >>> 14);
                else s2_next.cor_z[i] = 48'(acc >>> 14);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg) s2_reg <= s2_next;
    end

    // two lowest and two highest by y, ties to earlier index
    lever_item_t s3_next;
    always_comb
    begin
        logic [2:0] lo1, lo2, hi1, hi2;
        logic signed [48:0] sp, sa;
        logic signed [47:0] pv [3];
        logic signed [47:0] ac [3];
        if (s2_reg.cor_y[0] > s2_reg.cor_y[1]) begin lo1 = 3'd1; lo2 = 3'd0; end
        else begin lo1 = 3'd0; lo2 = 3'd1; end
        if (s2_reg.cor_y[0] < s2_reg.cor_y[1]) begin hi1 = 3'd1; hi2 = 3'd0; end
        else begin hi1 = 3'd0; hi2 = 3'd1; end
        for (int i = 2; i < 8; i++)
        begin
            if (s2_reg.cor_y[lo1] > s2_reg.cor_y[i]) begin lo2 = lo1; lo1 = 3'(i); end
            else if (s2_reg.cor_y[lo2] > s2_reg.cor_y[i]) lo2 = 3'(i);
            if (s2_reg.cor_y[hi1] < s2_reg.cor_y[i]) begin hi2 = hi1; hi1 = 3'(i); end
            else if (s2_reg.cor_y[hi2] < s2_reg.cor_y[i]) hi2 = 3'(i);
        end
        sp = 49'(s2_reg.cor_x[lo1]) + 49'(s2_reg.cor_x[lo2]);
        sa = 49'(s2_reg.cor_x[hi1]) + 49'(s2_reg.cor_x[hi2]);
        pv[0] = 48'(sp >>> 1); ac[0] = 48'(sa >>> 1);
        sp = 49'(s2_reg.cor_y[lo1]) + 49'(s2_reg.cor_y[lo2]);
        pv[1] = 48'(sp >>> 1);
        sp = 49'(s2_reg.cor_z[lo1]) + 49'(s2_reg.cor_z[lo2]);
        sa = 49'(s2_reg.cor_z[hi1]) + 49'(s2_reg.cor_z[hi2]);
        pv[2] = 48'(sp >>> 1); ac[2] = 48'(sa >>> 1);
        ac[1] = '0;
        s3_next.on_ground = s2_reg.on_ground;
        s3_next.piv_x = pv[0];
        s3_next.piv_y = pv[1];
        s3_next.piv_z = pv[2];
        s3_next.r_x = ac[0] - pv[0];
        s3_next.r_z = ac[2] - pv[2] + ac[1];
        s3_next.vel_x = s2_reg.vel_x;
        s3_next.vel_y = s2_reg.vel_y;
        s3_next.vel_z = s2_reg.vel_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg) s3_reg <= s3_next;
    end
endmodule

// ----- hdl/gcr_queue.sv -----
// short fifo between front and back end
`timescale 1ns / 1ps
module gcr_queue #(
    parameter int DEPTH = gcr_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 w_valid,
    output logic                 w_ready,
    input  gcr_pkg::lever_item_t w_item,
    output logic                 r_valid,
    input  logic                 r_ready,
    output gcr_pkg::lever_item_t r_item
);
    import gcr_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lever_item_t        mem_reg [DEPTH];
    logic [AW-1:0]      wp_reg, rp_reg;
    logic [AW:0]        cnt_reg;
    logic               wr, rd;

    assign w_ready = cnt_reg != (AW+1)'(DEPTH);
    assign r_valid = cnt_reg != '0;
    assign r_item  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= w_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

// ----- hdl/gcr_back.sv -----
// back end: torque and velocity products, saturation, output register
`timescale 1ns / 1ps
module gcr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcr_pkg::cfg_t        cfg,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  gcr_pkg::lever_item_t i_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   piv_x,
    output logic signed [31:0]   piv_y,
    output logic signed [31:0]   piv_z,
    output logic signed [31:0]   tq_x,
    output logic signed [31:0]   tq_z,
    output logic signed [31:0]   nv_x,
    output logic signed [31:0]   nv_y,
    output logic signed [31:0]   nv_z,
    output logic                 applied
);
    import gcr_pkg::*;

    // stage a: partial products (r split at bit 16) and velocity products
    logic               a_valid_reg;
    logic               a_gnd_reg;
    logic               a_neg_reg [2];
    logic [62:0]        a_hi_reg [2];
    logic [46:0]        a_lo_reg [2];
    logic signed [48:0] a_vp_reg [3];
    logic signed [31:0] a_v_reg [3];
    logic signed [31:0] a_piv_reg [3];
    // stage b: output register
    logic               b_valid_reg;

    logic adv_b, adv_a;
    assign adv_b = !b_valid_reg || out_ready;
    assign adv_a = !a_valid_reg || adv_b;
    assign i_ready = adv_a;
    assign out_valid = b_valid_reg;

    logic signed [47:0] rr [2];
    assign rr[0] = i_item.r_z;
    assign rr[1] = -i_item.r_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) a_valid_reg <= i_valid;
            if (adv_b) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [47:0] mag;
        if (adv_a && i_valid)
        begin
            for (int k = 0; k < 2; k++)
            begin
                mag = rr[k][47] ? 48'(-rr[k]) : 48'(rr[k]);
                a_neg_reg[k] <= rr[k][47];
                a_hi_reg[k] <= 63'(mag[47:16]) * 63'(cfg.push_force);
                a_lo_reg[k] <= 47'({16'd0, mag[15:0]} * {16'd0, cfg.push_force});
            end
            a_vp_reg[0] <= 49'(i_item.vel_x * $signed({1'b0, cfg.restitution}));
            a_vp_reg[1] <= 49'(i_item.vel_y * $signed({1'b0, cfg.restitution}));
            a_vp_reg[2] <= 49'(i_item.vel_z * $signed({1'b0, cfg.restitution}));
            a_v_reg[0] <= i_item.vel_x;
            a_v_reg[1] <= i_item.vel_y;
            a_v_reg[2] <= i_item.vel_z;
            a_piv_reg[0] <= sat32(64'(i_item.piv_x));
            a_piv_reg[1] <= sat32(64'(i_item.piv_y));
            a_piv_reg[2] <= sat32(64'(i_item.piv_z));
            a_gnd_reg <= i_item.on_ground;
        end
    end

    logic signed [31:0] tq [2];
    logic signed [31:0] nv [3];
    always_comb
    begin
        logic [63:0] q;
        logic signed [49:0] p;
        logic signed [31:0] s;
        logic [31:0] m;
        for (int k = 0; k < 2; k++)
        begin
            q = 64'(a_hi_reg[k]) + 64'(a_lo_reg[k][46:16]);
            if (a_neg_reg[k])
            begin
                q = q + 64'(a_lo_reg[k][15:0] != 16'd0);
                tq[k] = sat32(-$signed(q));
            end
            else tq[k] = sat32($signed(q));
        end
        for (int c = 0; c < 3; c++)
        begin
            p = -50'(a_vp_reg[c]);
            s = sat32(64'(p >>> 14));
            m = s[31] ? 32'(-33'(s)) : 32'(s);
            if (s == 32'sh80000000) m = 32'h80000000;
            if ({1'b0, m} < {2'b0, cfg.rest_threshold}) s = '0;
            nv[c] = s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && a_valid_reg)
        begin
            applied <= a_gnd_reg;
            if (a_gnd_reg)
            begin
                piv_x <= a_piv_reg[0];
                piv_y <= a_piv_reg[1];
                piv_z <= a_piv_reg[2];
                tq_x <= tq[0];
                tq_z <= tq[1];
                nv_x <= nv[0];
                nv_y <= nv[1];
                nv_z <= nv[2];
            end
            else
            begin
                piv_x <= '0;
                piv_y <= '0;
                piv_z <= '0;
                tq_x <= '0;
                tq_z <= '0;
                nv_x <= a_v_reg[0];
                nv_y <= '0;
                nv_z <= a_v_reg[2];
            end
        end
    end
endmodule

// ----- hdl/gcr_checker.sv -----
// port-level checker for the ground contact response block
`timescale 1ns / 1ps
`include "ground_contact_response_macros.svh"
module gcr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pivot_x,
    input logic signed [31:0] torque_x,
    input logic signed [31:0] torque_y,
    input logic signed [31:0] new_vel_y,
    input logic               force_applied
);
    `GCR_ASSERT_NXT(out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pivot_x))
    `GCR_ASSERT_IMP(ty_zero, clk, rst_n, out_valid, torque_y == 32'sd0)
    `GCR_ASSERT_IMP(no_contact, clk, rst_n, out_valid && !force_applied, torque_x == 32'sd0 && new_vel_y == 32'sd0)
    `GCR_ASSERT_NXT(idle_ready, clk, rst_n, !in_valid && !out_valid, in_ready)
endmodule

bind ground_contact_response gcr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pivot_x(pivot_x),
    .torque_x(torque_x), .torque_y(torque_y), .new_vel_y(new_vel_y),
    .force_applied(force_applied)
);
